/* src/quad_channel_quadrature_decoder_macros.svh */
// Assertion helpers; both sample on clk and stay quiet while arst_n is low.
`ifndef QUAD_CHANNEL_QUADRATURE_DECODER_MACROS_SVH
`define QUAD_CHANNEL_QUADRATURE_DECODER_MACROS_SVH

// Same-cycle implication.
`define QCQD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QCQD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/qcqd_pkg.sv */
package qcqd_pkg;

	localparam int unsigned NUM_CHANNELS = 4;
	localparam int unsigned PAIR_W       = 2;
	localparam int unsigned CNT_W        = 32;
	localparam int unsigned MASK_W       = 4;
	localparam logic [MASK_W-1:0] MASK_RESET = 4'd12;

	typedef enum logic [1:0] {
		OP_SAMPLE   = 2'd0,
		OP_START    = 2'd1,
		OP_CLR_POS  = 2'd2,
		OP_CLR_DIAG = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STEP_NONE,
		STEP_UP,
		STEP_DOWN,
		STEP_BAD
	} step_t;

	// Indexed by {previous pair, current pair}; pair is {A, B}.
	localparam step_t STEP_TABLE [16] = '{
		STEP_NONE, STEP_DOWN, STEP_UP,   STEP_BAD,
		STEP_UP,   STEP_NONE, STEP_BAD,  STEP_DOWN,
		STEP_DOWN, STEP_BAD,  STEP_NONE, STEP_UP,
		STEP_BAD,  STEP_UP,   STEP_DOWN, STEP_NONE
	};

	typedef struct packed {
		logic [1:0]        opcode;
		logic [PAIR_W-1:0] phase_pair_ch0;
		logic [PAIR_W-1:0] phase_pair_ch1;
		logic [PAIR_W-1:0] phase_pair_ch2;
		logic [PAIR_W-1:0] phase_pair_ch3;
	} item_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] position_ch0;
		logic signed [CNT_W-1:0] position_ch1;
		logic signed [CNT_W-1:0] position_ch2;
		logic signed [CNT_W-1:0] position_ch3;
		logic [CNT_W-1:0]        legal_steps_ch0;
		logic [CNT_W-1:0]        legal_steps_ch1;
		logic [CNT_W-1:0]        legal_steps_ch2;
		logic [CNT_W-1:0]        legal_steps_ch3;
		logic [CNT_W-1:0]        bad_steps_ch0;
		logic [CNT_W-1:0]        bad_steps_ch1;
		logic [CNT_W-1:0]        bad_steps_ch2;
		logic [CNT_W-1:0]        bad_steps_ch3;
	} result_t;

	// Control strobes shared by all channels, already qualified by the stage advancing.
	typedef struct packed {
		logic decode;
		logic capture;
		logic clr_pos;
		logic clr_diag;
	} chan_ctl_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] position;
		logic [CNT_W-1:0]        legal;
		logic [CNT_W-1:0]        bad;
	} chan_cnt_t;

endpackage

/* src/qcqd_if.sv */
interface qcqd_item_if;
	import qcqd_pkg::*;
	logic  valid;
	logic  ready;
	item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface qcqd_result_if;
	import qcqd_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* src/quad_channel_quadrature_decoder.sv */
// Channel   Dir   Payload                                   Transfer
// item      in    opcode, phase_pair_ch0..ch3                valid & ready
// result    out   position/legal_steps/bad_steps ch0..ch3    valid & ready
// wr_en     in    direction_invert_mask on wr_data           wr_en high
//
// One item per cycle while the result is not stalled; each passes the item register, then the result register.
// Item register feeds four channel decoders, whose outputs load the result register.
// A stalled result holds; the item register still takes one more item behind it.
// arst_n clears counters, baselines and the running flag; the mask resets to 12.
`include "quad_channel_quadrature_decoder_macros.svh"

module quad_channel_quadrature_decoder #(
	parameter int unsigned CHANNELS = qcqd_pkg::NUM_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [qcqd_pkg::MASK_W-1:0]   wr_data,
	qcqd_item_if.sink                     item,
	qcqd_result_if.source                 result
);
	import qcqd_pkg::*;

	logic [MASK_W-1:0] mask_q;
	logic              running_q;
	logic              valid_s1;
	item_t             item_s1;
	logic              res_valid_q;
	result_t           res_q;
	logic              advance;
	op_t               op;
	chan_ctl_t         ctl;
	logic [PAIR_W-1:0] pair [NUM_CHANNELS];
	chan_cnt_t         nxt [NUM_CHANNELS];

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign op         = op_t'(item_s1.opcode);

	assign ctl.decode   = advance && (op == OP_SAMPLE) && running_q;
	assign ctl.capture  = advance && (op == OP_START) && !running_q;
	assign ctl.clr_pos  = advance && (op == OP_CLR_POS);
	assign ctl.clr_diag = advance && (op == OP_CLR_DIAG);

	assign pair[0] = item_s1.phase_pair_ch0;
	assign pair[1] = item_s1.phase_pair_ch1;
	assign pair[2] = item_s1.phase_pair_ch2;
	assign pair[3] = item_s1.phase_pair_ch3;

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
		if (c < CHANNELS) begin : g_live
			qcqd_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.invert (mask_q[c]),
				.pair   (pair[c]),
				.nxt    (nxt[c])
			);
		end else begin : g_off
			assign nxt[c] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= MASK_RESET;
			running_q   <= 1'b0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				mask_q <= wr_data;
			end
			if (ctl.capture) begin
				running_q <= 1'b1;
			end
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
		if (advance) begin
			res_q.position_ch0    <= nxt[0].position;
			res_q.position_ch1    <= nxt[1].position;
			res_q.position_ch2    <= nxt[2].position;
			res_q.position_ch3    <= nxt[3].position;
			res_q.legal_steps_ch0 <= nxt[0].legal;
			res_q.legal_steps_ch1 <= nxt[1].legal;
			res_q.legal_steps_ch2 <= nxt[2].legal;
			res_q.legal_steps_ch3 <= nxt[3].legal;
			res_q.bad_steps_ch0   <= nxt[0].bad;
			res_q.bad_steps_ch1   <= nxt[1].bad;
			res_q.bad_steps_ch2   <= nxt[2].bad;
			res_q.bad_steps_ch3   <= nxt[3].bad;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	`QCQD_ASSERT_NEXT(a_running_sticky, running_q, running_q, "running flag dropped")
	`QCQD_ASSERT_NEXT(a_advance_shows, advance, res_valid_q, "advanced item not shown")
	`QCQD_ASSERT_NOW(a_ready_only_full, !item.ready,
		valid_s1 && res_valid_q && !result.ready, "input stalled without backpressure")
	`QCQD_ASSERT_NEXT(a_clear_pos, ctl.clr_pos,
		(res_q.position_ch0 == '0) && (res_q.position_ch3 == '0), "position clear missed")

endmodule

/* src/qcqd_chan.sv */
module qcqd_chan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qcqd_pkg::chan_ctl_t            ctl,
	input  logic                           invert,
	input  logic [qcqd_pkg::PAIR_W-1:0]    pair,
	output qcqd_pkg::chan_cnt_t            nxt
);
	import qcqd_pkg::*;

	logic [PAIR_W-1:0] last_q;
	chan_cnt_t         cnt_q;
	step_t             step;
	logic              legal;
	logic              forward;

	assign step    = STEP_TABLE[{last_q, pair}];
	assign legal   = (step == STEP_UP) || (step == STEP_DOWN);
	assign forward = (step == STEP_UP) ^ invert;

	always_comb begin
		nxt = cnt_q;
		if (ctl.decode && legal) begin
			nxt.legal    = cnt_q.legal + CNT_W'(1);
			nxt.position = forward ? cnt_q.position + CNT_W'(1)
				: cnt_q.position - CNT_W'(1);
		end
		if (ctl.decode && (step == STEP_BAD)) begin
			nxt.bad = cnt_q.bad + CNT_W'(1);
		end
		if (ctl.clr_pos) begin
			nxt.position = '0;
		end
		if (ctl.clr_diag) begin
			nxt.legal = '0;
			nxt.bad   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			cnt_q  <= '0;
		end else begin
			cnt_q <= nxt;
			if (ctl.decode || ctl.capture) begin
				last_q <= pair;
			end
		end
	end

endmodule
